>>> rtl/core/mhpq_pkg.sv
package mhpq_pkg;

    localparam int unsigned DEF_CAPACITY  = 1024;
    localparam int unsigned DEF_KEY_WIDTH = 32;
    localparam int unsigned OUT_KEY_W     = 32;

    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_PUSH  = 2'd1,
        OP_POP   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_cmd_t;

endpackage

>>> rtl/core/mhpq_cell.sv
module mhpq_cell
    import mhpq_pkg::*;
#(
    parameter int unsigned KEY_WIDTH = DEF_KEY_WIDTH,
    parameter int unsigned CNT_W     = 11,
    parameter int unsigned IDX       = 0
) (
    input  logic                 aclk,
    input  cell_cmd_t            cmd_i,
    input  logic [CNT_W-1:0]     count_i,
    input  logic [KEY_WIDTH-1:0] new_key_i,
    input  logic [KEY_WIDTH-1:0] left_key_i,
    input  logic                 left_gt_i,
    input  logic [KEY_WIDTH-1:0] right_key_i,
    output logic [KEY_WIDTH-1:0] key_o,
    output logic                 gt_o
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 occupied;

    assign occupied = count_i > CNT_W'(IDX);

    // An empty cell counts as holding a key larger than any other, so the
    // new key settles in the first cell whose key exceeds it.
    assign gt_o = !occupied || ($signed(new_key_i) < $signed(key_reg));

    always_comb begin
        key_next = key_reg;
        if (cmd_i.push) begin
            if (gt_o) begin
                key_next = left_gt_i ? left_key_i : new_key_i;
            end
        end else if (cmd_i.pop) begin
            key_next = right_key_i;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

    assign key_o = key_reg;

endmodule

>>> rtl/core/min_heap_priority_queue.sv
// Priority queue of signed keys that always presents its smallest entry.
// Requests arrive on the s_ channel (s_op, s_key under s_valid/s_ready):
// a query leaves the contents alone, a push inserts s_key, a pop removes
// the minimum. Every request yields exactly one result on the m_ channel:
// the minimum after the operation (0 when empty), the empty flag, the
// entry count and a status (refused push when full, pop on empty queue).
// Keys live in a row of CAPACITY cells kept in ascending order. On a push
// each cell compares the new key with its own and either keeps its key,
// takes the new one or takes its left neighbour's; on a pop every cell
// takes its right neighbour's key. Either way every cell updates together,
// so a result is valid on the cycle after acceptance, and a new request
// is taken every cycle while the result side keeps up. When m_ready is
// low the result holds and s_ready drops until it is taken. Reset empties
// the queue at once; the cells themselves are not cleared, as only
// occupied cells are ever read.
module min_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int unsigned CAPACITY  = DEF_CAPACITY,
    parameter int unsigned KEY_WIDTH = DEF_KEY_WIDTH,
    localparam int unsigned CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_op,
    input  logic [KEY_WIDTH-1:0] s_key,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [OUT_KEY_W-1:0] m_min_key,
    output logic                 m_is_empty,
    output logic [CNT_W-1:0]     m_count,
    output logic [1:0]           m_status
);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_valid_reg;
    logic                 m_valid_next;
    status_t              status_reg;
    status_t              status_next;
    logic                 accept;
    logic                 full;
    logic                 empty;
    cell_cmd_t            cmd;
    logic [KEY_WIDTH-1:0] key_w [CAPACITY];
    logic                 gt_w  [CAPACITY];
    logic [OUT_KEY_W-1:0] head_ext;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign full    = count_reg == CNT_W'(CAPACITY);
    assign empty   = count_reg == '0;

    always_comb begin
        cmd          = '0;
        count_next   = count_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (accept) begin
            m_valid_next = 1'b1;
            status_next  = ST_OK;
            case (s_op)
                OP_PUSH: begin
                    if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        cmd.push   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_POP: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        cmd.pop    = 1'b1;
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                default: begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= ST_OK;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [KEY_WIDTH-1:0] left_key;
        logic                 left_gt;
        logic [KEY_WIDTH-1:0] right_key;

        if (i == 0) begin : g_first
            assign left_key = s_key;
            assign left_gt  = 1'b0;
        end else begin : g_inner_left
            assign left_key = key_w[i-1];
            assign left_gt  = gt_w[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_key = key_w[i];
        end else begin : g_inner_right
            assign right_key = key_w[i+1];
        end

        mhpq_cell #(
            .KEY_WIDTH(KEY_WIDTH),
            .CNT_W    (CNT_W),
            .IDX      (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd_i      (cmd),
            .count_i    (count_reg),
            .new_key_i  (s_key),
            .left_key_i (left_key),
            .left_gt_i  (left_gt),
            .right_key_i(right_key),
            .key_o      (key_w[i]),
            .gt_o       (gt_w[i])
        );
    end

    if (KEY_WIDTH >= OUT_KEY_W) begin : g_out_trunc
        assign head_ext = key_w[0][OUT_KEY_W-1:0];
    end else begin : g_out_sext
        assign head_ext = {{(OUT_KEY_W - KEY_WIDTH){key_w[0][KEY_WIDTH-1]}}, key_w[0]};
    end

    // The queue only changes on an accepted request, which needs the result
    // slot to be free, so the live state doubles as the held result.
    assign m_valid    = m_valid_reg;
    assign m_min_key  = empty ? '0 : head_ext;
    assign m_is_empty = empty;
    assign m_count    = count_reg;
    assign m_status   = status_reg;

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_refused_push : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_PUSH && full) |=> $stable(count_reg))
        else $error("refused push changed the count");

    a_pop_count : assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_op == OP_POP && !empty) |=> count_reg == $past(count_reg) - CNT_W'(1))
        else $error("pop did not remove exactly one entry");

    a_head_order : assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> !($signed(key_w[1]) < $signed(key_w[0])))
        else $error("head cell does not hold the minimum");

    a_full_status : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> full)
        else $error("full status reported while space remains");

endmodule
